// ----- rtl/core/srlrs_pkg.sv -----
// Package for the regression statistic block: widths, constants, wide and multiplier types.
// No dependencies.
`default_nettype none
package srlrs_pkg;
  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned CntW       = 13;
  localparam int unsigned SampW      = 24;
  localparam int unsigned BigW       = 192;
  localparam int unsigned LogW       = 44;
  localparam logic [31:0] Ln2Q32     = 32'hB17217F8;
  localparam int unsigned FracBits   = 30;

  typedef logic [BigW-1:0] big_t;

  // shared multiplier request: 32x32 partial product
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/srlrs_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
// Depends on srlrs_pkg.
`default_nettype none
module srlrs_mul (
  input  wire logic               clk,
  input  wire srlrs_pkg::mul_req_t req,
  output logic [63:0]             prod
);
  import srlrs_pkg::*;
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= 64'(req.a) * 64'(req.b);
  end
  assign prod = prod_r;
endmodule
`default_nettype wire

// ----- rtl/core/simple_regression_lrs_top.sv -----
// Regression likelihood-ratio statistic: accumulates sample sums, fits on last beat.
// Plain beat: busy while its squares and cross product accumulate; start waits for idle.
// Last beat: busy through the fit on the shared 32x32 multiplier (8 wide products of
// 21 partial products), the 32-step divider and two 30-round log loops; a quotient
// overflow cuts the divider short, a perfect fit skips the logs, a bad fit ends at once.
// Sync reset clears sums and sequencer; out_valid strobes once as busy drops, no stall.
`default_nettype none
module simple_regression_lrs_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [23:0] in_trait_value,
  input  wire logic signed [23:0] in_marker_value,
  input  wire logic        in_last_sample,
  output logic             out_valid,
  output logic [31:0]      out_lrs,
  output logic signed [31:0] out_slope
);
  import srlrs_pkg::*;

  // state codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ACC  = 5'd1;  // squares/cross of the captured beat
  localparam logic [4:0] S_MUL  = 5'd2;  // multi-word multiply over partial products
  localparam logic [4:0] S_MULW = 5'd3;  // wait for registered product
  localparam logic [4:0] S_STEP = 5'd4;  // fit step dispatch
  localparam logic [4:0] S_DIV  = 5'd5;
  localparam logic [4:0] S_LOGM = 5'd6;
  localparam logic [4:0] S_LOGW = 5'd7;
  localparam logic [4:0] S_FIN  = 5'd8;
  localparam logic [4:0] S_LRS  = 5'd9;
  localparam logic [4:0] S_LRSW = 5'd10;
  localparam logic [4:0] S_OUT  = 5'd11;

  logic [4:0] state_r, state_nxt;

  // accumulators
  logic [CntW-1:0]        cnt_r;
  logic signed [35:0]     sy_r, sx_r;
  logic [59:0]            syy_r, sxx_r;
  logic signed [59:0]     sxy_r;
  logic signed [23:0]     y_r, x_r;
  logic                   last_r, take_r;

  // multiplier
  mul_req_t    mreq;
  logic [63:0] mprod;
  srlrs_mul u_mul (.clk(clk), .req(mreq), .prod(mprod));

  // bignum multiply engine: op_a * op_b -> prod, low BigW bits
  big_t        opa_r, opb_r, bacc_r;
  logic [2:0]  mi_r, mj_r;
  logic [2:0]  acc_sub_r;        // 0: y*y, 1: x*x, 2: x*y
  logic [3:0]  step_r;           // fit step index
  big_t        dn_r, tn_r, cn_r, p_r, q_r, t1_r;
  logic        cneg_r, bad_r;
  logic [31:0] qt_r, lrs_r, slope_r;
  logic [5:0]  dcnt_r;
  logic [63:0] m_r;
  logic [29:0] f_r;
  logic [4:0]  lcnt_r;
  logic [8:0]  len_r;
  logic        lsel_r;           // 0: log of p, 1: log of q
  logic [LogW-1:0] lp_r;
  logic [63:0] g_r;
  logic        lph_r;            // lrs product phase

  // magnitudes
  logic [35:0] ax, ay;
  logic [59:0] axy;
  assign ax  = sx_r[35] ? 36'(-sx_r) : 36'(sx_r);
  assign ay  = sy_r[35] ? 36'(-sy_r) : 36'(sy_r);
  assign axy = sxy_r[59] ? 60'(-sxy_r) : 60'(sxy_r);

  function automatic int unsigned bitlen(input big_t v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < BigW; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  // operand word select for the multiply engine
  logic [31:0] wa, wb;
  assign wa = opa_r[32*mi_r +: 32];
  assign wb = opb_r[32*mj_r +: 32];

  // sample products on the shared unit: magnitudes, sign fixed after
  logic [23:0] my, mx;
  assign my = y_r[23] ? 24'(-y_r) : 24'(y_r);
  assign mx = x_r[23] ? 24'(-x_r) : 24'(x_r);

  always_comb begin
    mreq = '0;
    unique case (state_r)
      S_ACC: begin
        unique case (acc_sub_r)
          3'd0:    mreq = '{a: 32'(my), b: 32'(my)};
          3'd1:    mreq = '{a: 32'(mx), b: 32'(mx)};
          default: mreq = '{a: 32'(mx), b: 32'(my)};
        endcase
      end
      S_MUL:  mreq = '{a: wa, b: wb};
      S_LOGM: mreq = '{a: m_r[31:0], b: m_r[31:0]};
      S_LRS:  mreq = '{a: (lph_r ? g_r[63:32] : g_r[31:0]), b: Ln2Q32};
      default: mreq = '0;
    endcase
  end

  // log seed: top 32 bits of p, or of q while the log of p finishes
  big_t        lsrc;
  int unsigned blen;
  big_t        lnorm;
  assign lsrc  = (state_r == S_LOGW) ? q_r : p_r;
  assign blen  = bitlen(lsrc);
  assign lnorm = (blen >= 32) ? (lsrc >> (blen - 32)) : (lsrc << (32 - blen));

  // divider trial
  big_t dsh;
  assign dsh = dn_r << dcnt_r[4:0];

  logic [63:0] msq;
  assign msq = mprod >> 31;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      sy_r      <= '0; sx_r <= '0; syy_r <= '0; sxx_r <= '0; sxy_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      state_r   <= state_nxt;
      unique case (state_r)
        S_IDLE: if (start) begin
          y_r <= in_trait_value; x_r <= in_marker_value;
          last_r <= in_last_sample;
          take_r <= (32'(cnt_r) < MaxSamples);
          acc_sub_r <= 3'd0;
        end
        S_ACC: begin
          // product of the previous sub-step comes from the registered multiplier
          acc_sub_r <= acc_sub_r + 3'd1;
          if (take_r) begin
            unique case (acc_sub_r)
              3'd0: begin
                cnt_r <= cnt_r + 1'b1;
                sy_r  <= sy_r + 36'(y_r);
                sx_r  <= sx_r + 36'(x_r);
              end
              3'd1: syy_r <= syy_r + 60'(mprod);
              3'd2: sxx_r <= sxx_r + 60'(mprod);
              3'd3: sxy_r <= ((y_r[23] ^ x_r[23]) ? sxy_r - 60'(mprod)
                                                  : sxy_r + 60'(mprod));
              default: ;
            endcase
          end
          if (acc_sub_r == 3'd3) begin
            step_r <= 4'd0;
            bad_r  <= 1'b0;
          end
        end
        S_STEP: begin
          // load operands for the next product, or combine results
          mi_r <= '0; mj_r <= '0; bacc_r <= '0;
          unique case (step_r)
            4'd0: begin opa_r <= BigW'(cnt_r); opb_r <= BigW'(sxx_r); end
            4'd1: begin t1_r <= bacc_r; opa_r <= BigW'(ax); opb_r <= BigW'(ax); end
            4'd2: begin
              if (t1_r <= bacc_r) bad_r <= 1'b1;
              dn_r <= t1_r - bacc_r;
              opa_r <= BigW'(cnt_r); opb_r <= BigW'(syy_r);
            end
            4'd3: begin t1_r <= bacc_r; opa_r <= BigW'(ay); opb_r <= BigW'(ay); end
            4'd4: begin
              if (t1_r <= bacc_r) bad_r <= 1'b1;
              tn_r <= t1_r - bacc_r;
              opa_r <= BigW'(cnt_r); opb_r <= BigW'(axy);
            end
            4'd5: begin t1_r <= bacc_r; opa_r <= BigW'(ax); opb_r <= BigW'(ay); end
            4'd6: begin
              if (sxy_r[59] != (sx_r[35] ^ sy_r[35])) begin
                cn_r <= t1_r + bacc_r; cneg_r <= sxy_r[59];
              end else if (t1_r >= bacc_r) begin
                cn_r <= t1_r - bacc_r; cneg_r <= sxy_r[59];
              end else begin
                cn_r <= bacc_r - t1_r; cneg_r <= !sxy_r[59];
              end
              opa_r <= tn_r; opb_r <= dn_r;
            end
            4'd7: begin p_r <= bacc_r; opa_r <= cn_r; opb_r <= cn_r; end
            4'd8: begin
              if (bacc_r > p_r) bad_r <= 1'b1;
              q_r  <= p_r - bacc_r;
              t1_r <= cn_r << 16;
              qt_r <= '0;
              dcnt_r <= 6'd31;
            end
            default: ;
          endcase
          step_r <= step_r + 4'd1;
        end
        S_MULW: begin
          // accumulate partial product at word offset i+j, drop beyond width
          bacc_r <= bacc_r + (BigW'(mprod) << (32 * (32'(mi_r) + 32'(mj_r))));
          if (32'(mi_r) + 32'(mj_r) + 1 < 6) mj_r <= mj_r + 3'd1;
          else begin
            mj_r <= '0;
            mi_r <= mi_r + 3'd1;
          end
        end
        S_DIV: begin
          if (dcnt_r == 6'd31 && qt_r == '0 && t1_r >= (dn_r << 32)) begin
            qt_r <= 32'hFFFFFFFF;
            dcnt_r <= 6'h3F;
          end else begin
            if (t1_r >= dsh) begin
              t1_r <= t1_r - dsh;
              qt_r[dcnt_r[4:0]] <= 1'b1;
            end
            dcnt_r <= dcnt_r - 6'd1;
          end
          if (dcnt_r == 6'd0 || dcnt_r == 6'h3F) begin
            lsel_r <= 1'b0;
            lcnt_r <= '0;
            f_r    <= '0;
            m_r    <= 64'(lnorm[31:0]);
            len_r  <= 9'(blen);
          end
        end
        S_LOGW: begin
          lcnt_r <= lcnt_r + 5'd1;
          if (msq[32]) begin
            m_r <= msq >> 1;
            f_r <= {f_r[28:0], 1'b1};
          end else begin
            m_r <= msq;
            f_r <= {f_r[28:0], 1'b0};
          end
          if (lcnt_r == 5'(FracBits - 1)) begin
            if (!lsel_r) begin
              lp_r   <= {LogW'(len_r - 9'd1) << FracBits} | LogW'({f_r[28:0], msq[32]});
              lsel_r <= 1'b1;
              lcnt_r <= '0;
              f_r    <= '0;
              m_r    <= 64'(lnorm[31:0]);
              len_r  <= 9'(blen);
            end else begin
              // g = lp - lq clamped, times n
              logic [LogW-1:0] lq;
              lq = (LogW'(len_r - 9'd1) << FracBits) | LogW'({f_r[28:0], msq[32]});
              g_r <= (lp_r > lq) ? 64'(lp_r - lq) * 64'(cnt_r) : 64'd0;
              lph_r <= 1'b0;
            end
          end
        end
        S_LRSW: begin
          if (!lph_r) begin
            bacc_r <= BigW'(mprod >> 32);
            lph_r  <= 1'b1;
          end else begin
            logic [63:0] accv;
            accv = (mprod + 64'(bacc_r)) >> 14;
            lrs_r <= (accv > 64'hFFFFFFFF) ? 32'hFFFFFFFF : accv[31:0];
          end
        end
        S_FIN: begin
          // slope saturation; q of zero saturates lrs (a bad fit zeros both at output)
          if (cneg_r) slope_r <= (qt_r > 32'h80000000) ? 32'h80000000 : 32'(-qt_r);
          else        slope_r <= (qt_r > 32'h7FFFFFFF) ? 32'h7FFFFFFF : qt_r;
          if (q_r == '0) lrs_r <= 32'hFFFFFFFF;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_lrs   <= bad_r ? 32'd0 : lrs_r;
          out_slope <= bad_r ? 32'sd0 : slope_r;
          cnt_r <= '0; sy_r <= '0; sx_r <= '0; syy_r <= '0; sxx_r <= '0; sxy_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_ACC;
      S_ACC:  if (acc_sub_r == 3'd3) state_nxt = last_r ? S_STEP : S_IDLE;
      S_STEP: begin
        if (step_r == 4'd2 && t1_r <= bacc_r) state_nxt = S_OUT;
        else if (step_r == 4'd4 && t1_r <= bacc_r) state_nxt = S_OUT;
        else if (step_r == 4'd8) state_nxt = (bacc_r > p_r) ? S_OUT : S_DIV;
        else state_nxt = S_MUL;
      end
      S_MUL:  state_nxt = S_MULW;
      S_MULW: state_nxt = (32'(mi_r) == 5 && 32'(mj_r) == 0) ? S_STEP : S_MUL;
      S_DIV:  if (dcnt_r == 6'd0 || dcnt_r == 6'h3F) state_nxt = S_FIN;
      S_FIN:  state_nxt = (q_r == '0) ? S_OUT : S_LOGM;
      S_LOGM: state_nxt = S_LOGW;
      S_LOGW: state_nxt = (lcnt_r == 5'(FracBits - 1) && lsel_r) ? S_LRS : S_LOGM;
      S_LRS:  state_nxt = S_LRSW;
      S_LRSW: state_nxt = lph_r ? S_OUT : S_LRS;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // the strobe only follows a finished fit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_OUT)
    else $error("result strobe without fit completion");
  // a beat taken while idle raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");
  // sample count never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MaxSamples)
    else $error("sample count overflow");
endmodule
`default_nettype wire

// ----- tb/srlrs_checker.sv -----
// Checker for the regression statistic block: watches the sample and result channels,
// predicts each result from its own copy of the sums and compares field by field.
// Depends on srlrs_pkg for the sample limit, the wide integer type and ln 2.
`default_nettype none
module srlrs_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [23:0] in_trait_value,
  input  wire logic signed [23:0] in_marker_value,
  input  wire logic               in_last_sample,
  input  wire logic               out_valid,
  input  wire logic [31:0]        out_lrs,
  input  wire logic signed [31:0] out_slope,
  output int                      fail_count,
  output int                      pending
);
  import srlrs_pkg::*;

  typedef struct {
    logic [31:0] lrs;
    logic [31:0] slope;
  } fit_t;

  typedef logic signed [BigW-1:0] sbig_t;

  fit_t        fit_q[$];
  int unsigned n_held;
  longint      sy, sx, sxy;
  longint unsigned syy, sxx;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic longint unsigned log2_q30(input big_t v);
    int len;
    big_t t;
    longint unsigned m, f;
    len = 0;
    for (int i = BigW - 1; i >= 0; i--) begin
      if (v[i]) begin
        len = i + 1;
        break;
      end
    end
    t = (len >= 32) ? (v >> (len - 32)) : (v << (32 - len));
    m = t[31:0];
    f = 0;
    repeat (FracBits) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return (longint'(len - 1) << FracBits) + f;
  endfunction

  // Fit the held sums; zero outputs on a degenerate fit.
  function automatic fit_t fit_sums();
    fit_t r;
    big_t nb, dn, tn, cmag, p, c2, q, num;
    sbig_t cs;
    logic cneg;
    longint unsigned qt, lp, lq, g, t, th, tl, acc;
    r.lrs = '0;
    r.slope = '0;
    nb = big_t'(n_held);
    if (nb * big_t'(sxx) <= big_t'(sbig_t'(sx) * sbig_t'(sx))) return r;
    dn = nb * big_t'(sxx) - big_t'(sbig_t'(sx) * sbig_t'(sx));
    if (nb * big_t'(syy) <= big_t'(sbig_t'(sy) * sbig_t'(sy))) return r;
    tn = nb * big_t'(syy) - big_t'(sbig_t'(sy) * sbig_t'(sy));
    cs = sbig_t'(n_held) * sbig_t'(sxy) - sbig_t'(sx) * sbig_t'(sy);
    cneg = cs < 0;
    cmag = cneg ? big_t'(-cs) : big_t'(cs);
    p = tn * dn;
    c2 = cmag * cmag;
    if (c2 > p) return r;
    q = p - c2;
    num = cmag << 16;
    if (num >= (dn << 32)) qt = 64'hFFFF_FFFF;
    else qt = longint'(num / dn);
    if (cneg) begin
      if (qt > 64'h8000_0000) qt = 64'h8000_0000;
      r.slope = 32'(-qt);
    end else begin
      if (qt > 64'h7FFF_FFFF) qt = 64'h7FFF_FFFF;
      r.slope = qt[31:0];
    end
    if (q == '0) begin
      r.lrs = 32'hFFFF_FFFF;
      return r;
    end
    lp = log2_q30(p);
    lq = log2_q30(q);
    g = (lp > lq) ? lp - lq : 0;
    t = g * n_held;
    th = t >> 32;
    tl = t & 64'hFFFF_FFFF;
    acc = (th * Ln2Q32 + ((tl * Ln2Q32) >> 32)) >> 14;
    r.lrs = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    return r;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    fit_t want;
    if (!rst_n) begin
      n_held = 0; sy = 0; sx = 0; sxy = 0; syy = 0; sxx = 0;
    end else begin
      // drain results before taking this edge's beat
      if (out_valid) begin
        if (fit_q.size() == 0) begin
          $display("unexpected result lrs %h slope %h at %0t", out_lrs, out_slope,
                   $realtime);
          fail_count++;
        end else begin
          want = fit_q.pop_front();
          if (out_lrs !== want.lrs) report_mismatch("lrs", out_lrs, want.lrs);
          if (out_slope !== want.slope) report_mismatch("slope", out_slope, want.slope);
        end
      end
      if (start && !busy) begin
        if (n_held < MaxSamples) begin
          n_held++;
          sy  += longint'(in_trait_value);
          sx  += longint'(in_marker_value);
          syy += longint'(in_trait_value) * longint'(in_trait_value);
          sxx += longint'(in_marker_value) * longint'(in_marker_value);
          sxy += longint'(in_trait_value) * longint'(in_marker_value);
        end
        if (in_last_sample) begin
          fit_q.push_back(fit_sums());
          n_held = 0; sy = 0; sx = 0; sxy = 0; syy = 0; sxx = 0;
        end
      end
    end
    pending = fit_q.size();
  end
endmodule
`default_nettype wire

// ----- tb/tb_simple_regression_lrs_top.sv -----
// Testbench top for simple_regression_lrs_top: drives sample sets, directed then random,
// and gives the verdict. Depends on srlrs_pkg, the block and srlrs_checker.
`default_nettype none
module tb_simple_regression_lrs_top;
  import srlrs_pkg::*;

  localparam int CycleLimit = 5000000;
  localparam int FitLatency = 800;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [23:0] in_trait_value;
  logic signed [23:0] in_marker_value;
  logic               in_last_sample;
  logic               out_valid;
  logic [31:0]        out_lrs;
  logic signed [31:0] out_slope;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 idle_pct;
  int                 beats_sent;

  simple_regression_lrs_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_trait_value(in_trait_value), .in_marker_value(in_marker_value),
    .in_last_sample(in_last_sample), .out_valid(out_valid),
    .out_lrs(out_lrs), .out_slope(out_slope)
  );

  srlrs_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_trait_value(in_trait_value), .in_marker_value(in_marker_value),
    .in_last_sample(in_last_sample), .out_valid(out_valid),
    .out_lrs(out_lrs), .out_slope(out_slope),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Watchdog: abort a hung run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one beat; entered and left just after a falling edge. Idle first at random,
  // then hold start until the block takes the beat.
  task automatic send_beat(input logic signed [23:0] y, input logic signed [23:0] x,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_trait_value <= y;
    in_marker_value <= x;
    in_last_sample <= last;
    do @(posedge clk); while (busy);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // Pick a marker value: full range or a narrow band, so fits stay well conditioned.
  function automatic logic signed [23:0] pick_marker(input int span);
    if (span == 0) return 24'($urandom);
    return 24'(int'($urandom_range(2 * span)) - span);
  endfunction

  // One sample set of n beats. Styles: 0 independent noise, 1 linear with noise,
  // 2 exact line (perfect fit), 3 constant marker, 4 constant trait.
  task automatic send_set(input int n, input int style);
    int span, gain, noise, shift;
    logic signed [23:0] x, y, x0, y0;
    span  = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(4, 20));
    gain  = int'($urandom_range(64)) - 32;
    shift = $urandom_range(5);
    noise = 1 << $urandom_range(0, 22);
    x0 = 24'($urandom);
    y0 = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      x = pick_marker(span);
      case (style)
        0: y = 24'($urandom);
        1: y = clamp24(((longint'(x) * gain) >>> shift)
                       + longint'(int'($urandom_range(2 * noise)) - noise));
        2: y = clamp24((longint'(x) * gain) >>> shift);
        3: begin
          x = x0;
          y = 24'($urandom);
        end
        default: y = y0;
      endcase
      send_beat(y, x, i == n - 1);
    end
  endtask

  // Drop start and hold off until every expected result has come.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_trait_value = '0;
    in_marker_value = '0;
    in_last_sample = 1'b0;
    idle_pct = 28;
    beats_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: single sample set, field extremes, perfect fit, constant columns,
    // saturating slopes of both signs.
    send_beat(24'sd8388607, -24'sd8388608, 1'b1);
    send_beat(-24'sd8388608, 24'sd8388607, 1'b0);
    send_beat(24'sd8388607, -24'sd8388608, 1'b0);
    send_beat(-24'sd8388608, -24'sd8388608, 1'b1);
    send_beat(24'sd4096, 24'sd4096, 1'b0);
    send_beat(24'sd8192, 24'sd8192, 1'b0);
    send_beat(24'sd12288, 24'sd12288, 1'b1);
    send_beat(24'sd5, 24'sd7, 1'b0);
    send_beat(-24'sd9, 24'sd7, 1'b0);
    send_beat(24'sd100, 24'sd7, 1'b1);
    send_beat(24'sd3, 24'sd1, 1'b0);
    send_beat(24'sd3, -24'sd1, 1'b0);
    send_beat(24'sd3, 24'sd0, 1'b1);
    send_beat(-24'sd8388608, 24'sd0, 1'b0);
    send_beat(24'sd8388607, 24'sd1, 1'b0);
    send_beat(24'sd0, 24'sd0, 1'b1);
    send_beat(24'sd8388607, 24'sd0, 1'b0);
    send_beat(-24'sd8388608, 24'sd1, 1'b0);
    send_beat(24'sd0, 24'sd0, 1'b1);
    send_beat(24'sd0, 24'sd0, 1'b1);
    send_beat(24'sd100, -24'sd50, 1'b0);
    send_beat(24'sd301, -24'sd150, 1'b0);
    send_beat(-24'sd99, 24'sd50, 1'b1);

    // Hold off until every fit is out, then run one long set.
    wait_drained();
    send_set(300, 1);

    // Random sets in three idling phases: light, heavy, none.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 86 : 0;
      n = beats_sent;
      while (beats_sent - n < 500) begin
        if ($urandom_range(19) == 0) send_set($urandom_range(100, 400), $urandom_range(4));
        else send_set($urandom_range(1, 30), $urandom_range(9) < 6 ?
                      $urandom_range(1) : $urandom_range(4));
      end
      wait_drained();
    end

    repeat (FitLatency) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/srlrs_pkg.sv
rtl/core/srlrs_mul.sv
rtl/core/simple_regression_lrs_top.sv
tb/srlrs_checker.sv
tb/tb_simple_regression_lrs_top.sv
